[sv/lba_to_chs_read_splitter_defines.svh]
// Assertion macros shared by the LBA to CHS read splitter RTL.
`ifndef LBA_TO_CHS_READ_SPLITTER_DEFINES_SVH
`define LBA_TO_CHS_READ_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCHS_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("lchs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCHS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("lchs check failed");

`endif

[sv/lchs_pkg.sv]
// Types and constants shared by the LBA to CHS read splitter.
`default_nettype none
package lchs_pkg;

  localparam int unsigned LBA_W     = 24;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned SPT_W     = 6;
  localparam int unsigned HEADS_W   = 9;
  localparam int unsigned DRIVE_W   = 8;
  localparam int unsigned CYL_W     = 10;
  localparam int unsigned SECTOR_SH = 9;

  localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd18;
  localparam logic [HEADS_W-1:0] HEADS_RESET = 9'd2;
  localparam logic [DRIVE_W-1:0] DRIVE_RESET = 8'd0;

  typedef enum logic [1:0] {
    REG_SPT   = 2'd0,
    REG_HEADS = 2'd1,
    REG_DRIVE = 2'd2,
    REG_NONE  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_SECTOR,
    ST_DIV_HEAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [LBA_W-1:0]   start_block;
    logic [COUNT_W-1:0] sector_total;
    logic [ADDR_W-1:0]  buffer_address;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] chunk_sectors;
    logic [15:0]        cyl_sector_word;
    logic [15:0]        head_drive_word;
    logic [15:0]        buffer_segment;
    logic [3:0]         buffer_offset;
    logic               last_chunk;
  } chunk_t;

  typedef struct packed {
    logic [1:0]         reg_index;
    logic [HEADS_W-1:0] wr_data;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

[sv/lchs_stream_if.sv]
// Valid/ready channel carrying one payload beat.
`default_nettype none
interface lchs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/lba_to_chs_read_splitter.sv]
// Top level of the LBA to CHS read splitter.
// One request beat (start block, sector count, linear buffer address) is taken only while
// the block is idle. It is turned into a sector and track by a bit-serial divide by the
// sectors-per-track register, then into head and cylinder by a second bit-serial divide by
// the head count register; both use one shared divider, and the first chunk beat is shown
// once the second divide is done. Every further chunk of the request is shown in the cycle
// after the one before it is taken: a chunk that fills its track moves on to sector zero of
// the next track, where the head steps, and the cylinder on head wrap, and a chunk cut short
// by CHUNK_CAP moves on along the same track. A request of n sectors ends after its last
// chunk is taken (at most 64 chunks, and one chunk when the count is zero). Counts above
// MAX_REQUEST are saturated; a zero geometry register is treated as 1. Configuration beats
// are always accepted and must be written only while no request is in flight.
`default_nettype none
module lba_to_chs_read_splitter #(
  parameter int unsigned MAX_REQUEST = 64,
  parameter int unsigned CHUNK_CAP   = 127
) (
  input  logic          clk,
  input  logic          rst_n,
  lchs_stream_if.sink   in_req,
  lchs_stream_if.source out_chunk,
  lchs_stream_if.sink   cfg_wr
);
  import lchs_pkg::*;
  `include "lba_to_chs_read_splitter_defines.svh"

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_REQUEST);
  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CHUNK_CAP);

  // Geometry and drive registers.
  logic [SPT_W-1:0]   spt_r;
  logic [HEADS_W-1:0] heads_r;
  logic [DRIVE_W-1:0] drive_r;
  logic [SPT_W-1:0]   spt_eff;
  logic [HEADS_W-1:0] heads_eff;
  cfg_t               cfg_beat;

  // Request state.
  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [SPT_W-1:0]   sector_r, sector_nxt;
  logic [HEADS_W-1:0] head_r, head_nxt;
  logic [CYL_W-1:0]   cyl_r, cyl_nxt;

  // Handshake and chunk math.
  req_t               req_beat;
  chunk_t             chunk;
  logic               in_ready, out_valid, out_fire;
  logic [COUNT_W-1:0] req_count;
  logic [COUNT_W-1:0] room, take;
  logic               trk_end;
  logic [HEADS_W-1:0] head_inc;

  // Divider hookup.
  logic                div_start;
  logic [LBA_W-1:0]    div_dividend;
  logic [HEADS_W-1:0]  div_divisor;
  logic [LBA_W-1:0]    div_quot;
  logic [HEADS_W-1:0]  div_rem;
  div_stat_t           div_stat;

  assign cfg_beat     = cfg_wr.payload;
  assign cfg_wr.ready = 1'b1;
  assign req_beat     = in_req.payload;
  assign in_req.ready = in_ready;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= SPT_RESET;
      heads_r <= HEADS_RESET;
      drive_r <= DRIVE_RESET;
    end else if (cfg_wr.valid) begin
      unique case (reg_index_t'(cfg_beat.reg_index))
        REG_SPT:   spt_r   <= cfg_beat.wr_data[SPT_W-1:0];
        REG_HEADS: heads_r <= cfg_beat.wr_data;
        REG_DRIVE: drive_r <= cfg_beat.wr_data[DRIVE_W-1:0];
        REG_NONE:  ;
        default:   ;
      endcase
    end
  end

  assign spt_eff   = (spt_r == '0) ? SPT_W'(1) : spt_r;
  assign heads_eff = (heads_r == '0) ? HEADS_W'(1) : heads_r;

  lchs_div #(
    .DIVIDEND_W (LBA_W),
    .DIVISOR_W  (HEADS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  // Chunk size: the sectors left on the track, capped, then by the sectors still wanted.
  // A chunk that reaches the track end steps the head, and the cylinder on head wrap.
  always_comb begin
    room = COUNT_W'(spt_eff - sector_r);
    if (room > CAP_CNT) begin
      room = CAP_CNT;
    end
    take       = (count_r > room) ? room : count_r;
    count_nxt  = count_r - take;
    addr_nxt   = addr_r + (ADDR_W'(take) << SECTOR_SH);
    trk_end    = ((COUNT_W'(sector_r) + take) == COUNT_W'(spt_eff));
    head_inc   = head_r + HEADS_W'(1);
    sector_nxt = sector_r + SPT_W'(take);
    head_nxt   = head_r;
    cyl_nxt    = cyl_r;
    if (trk_end) begin
      sector_nxt = '0;
      if (head_inc == heads_eff) begin
        head_nxt = '0;
        cyl_nxt  = cyl_r + CYL_W'(1);
      end else begin
        head_nxt = head_inc;
      end
    end
  end

  // Chunk beat, built from the request state while it is shown.
  always_comb begin
    chunk.chunk_sectors   = take;
    chunk.cyl_sector_word = {cyl_r[7:0], cyl_r[9:8], sector_r + SPT_W'(1)};
    chunk.head_drive_word = {head_r[7:0], drive_r};
    chunk.buffer_segment  = addr_r[ADDR_W-1:4];
    chunk.buffer_offset   = addr_r[3:0];
    chunk.last_chunk      = (count_nxt == '0);
  end

  assign out_chunk.valid   = out_valid;
  assign out_chunk.payload = chunk;
  assign out_fire          = out_valid && out_chunk.ready;
  assign req_count = (req_beat.sector_total > MAX_CNT) ? MAX_CNT : req_beat.sector_total;

  // Sequencer: two divides, then one chunk beat per cycle the output is taken.
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    div_start    = 1'b0;
    div_dividend = req_beat.start_block;
    div_divisor  = HEADS_W'(spt_eff);
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_req.valid) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_SECTOR;
        end
      end
      ST_DIV_SECTOR: begin
        div_dividend = div_quot;
        div_divisor  = heads_eff;
        if (div_stat.done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_HEAD;
        end
      end
      ST_DIV_HEAD: begin
        if (div_stat.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_chunk.ready && chunk.last_chunk) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request state updates; each chunk advances the position by the sectors it took.
  always_ff @(posedge clk) begin
    if (in_ready && in_req.valid) begin
      count_r <= req_count;
      addr_r  <= req_beat.buffer_address;
    end
    if (state_r == ST_DIV_SECTOR && div_stat.done) begin
      sector_r <= div_rem[SPT_W-1:0];
    end
    if (state_r == ST_DIV_HEAD && div_stat.done) begin
      head_r <= div_rem;
      cyl_r  <= div_quot[CYL_W-1:0];
    end
    if (out_fire) begin
      count_r  <= count_nxt;
      addr_r   <= addr_nxt;
      sector_r <= sector_nxt;
      head_r   <= head_nxt;
      cyl_r    <= cyl_nxt;
    end
  end

  `LCHS_ASSERT_NEXT(a_more_chunks, clk, rst_n, out_fire && !chunk.last_chunk, out_valid)
  `LCHS_ASSERT_IMPLY(a_empty_is_last, clk, rst_n, out_valid && take == '0,
                     chunk.last_chunk)
  `LCHS_ASSERT_IMPLY(a_track_bound, clk, rst_n, out_valid,
                     (COUNT_W'(sector_r) + take) <= COUNT_W'(spt_eff))
  `LCHS_ASSERT_IMPLY(a_idle_quiet, clk, rst_n, in_ready, !out_valid && !div_stat.busy)
endmodule
`default_nettype wire

[sv/lchs_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module lchs_div #(
  parameter int unsigned DIVIDEND_W = 24,
  parameter int unsigned DIVISOR_W  = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quot,
  output logic [DIVISOR_W-1:0]  rem,
  output lchs_pkg::div_stat_t   stat
);
  import lchs_pkg::*;
  `include "lba_to_chs_read_splitter_defines.svh"

  localparam int unsigned CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic [DIVIDEND_W-1:0] quot_r, quot_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvsr_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r, done_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem_r, quot_r[DIVIDEND_W-1]};
    fits     = (trial >= {1'b0, dvsr_r});
    rem_nxt  = fits ? DIVISOR_W'(trial - {1'b0, dvsr_r}) : trial[DIVISOR_W-1:0];
    quot_nxt = {quot_r[DIVIDEND_W-2:0], fits};
  end

  // Control: busy for one cycle per dividend bit, then a done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign quot      = quot_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `LCHS_ASSERT_NEXT(a_div_starts, clk, rst_n, start, busy_r && !done_r)
  `LCHS_ASSERT_IMPLY(a_div_done_idle, clk, rst_n, done_r, !busy_r)
  `LCHS_ASSERT_NEXT(a_div_runs, clk, rst_n, busy_r && !start && cnt_r != CNT_LAST,
                    busy_r)
endmodule
`default_nettype wire

[sim/lba_to_chs_read_splitter_tb.sv]
// Self-checking testbench for the LBA to CHS read splitter.
`timescale 1ns / 1ps
module lba_to_chs_read_splitter_tb;
  import lchs_pkg::*;

  localparam int unsigned MAX_REQUEST = 64;
  localparam int unsigned CHUNK_CAP   = 127;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_ITEMS = 39;
  localparam int unsigned END_CYCLES  = 64;

  // Predicts the chunk beats of each request and checks them in order.
  class chunk_scoreboard;
    logic [SPT_W-1:0]   spt;
    logic [HEADS_W-1:0] heads;
    logic [DRIVE_W-1:0] drive;
    chunk_t             expected_chunks[$];
    int                 errors;

    function new();
      spt    = SPT_RESET;
      heads  = HEADS_RESET;
      drive  = DRIVE_RESET;
      errors = 0;
    endfunction

    // Each register keeps only the bits of its own width.
    function void set_reg(logic [1:0] idx, logic [HEADS_W-1:0] data);
      case (idx)
        REG_SPT:   spt   = data[SPT_W-1:0];
        REG_HEADS: heads = data;
        REG_DRIVE: drive = data[DRIVE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_chunks.size();
    endfunction

    // Split one accepted request into track-bounded chunks.
    function void note_request(req_t req);
      int unsigned lba;
      int unsigned left;
      logic [ADDR_W-1:0] addr;
      int unsigned sec_per_trk;
      int unsigned num_heads;
      int unsigned sector;
      int unsigned track;
      int unsigned cyl;
      int unsigned head;
      int unsigned room;
      int unsigned take;
      int unsigned n;
      chunk_t c;
      lba         = req.start_block;
      left        = req.sector_total;
      addr        = req.buffer_address;
      sec_per_trk = (spt == 0) ? 1 : spt;
      num_heads   = (heads == 0) ? 1 : heads;
      n           = 0;
      if (left > MAX_REQUEST) left = MAX_REQUEST;
      do begin
        sector = lba % sec_per_trk;
        track  = lba / sec_per_trk;
        cyl    = track / num_heads;
        head   = track % num_heads;
        room   = sec_per_trk - sector;
        if (room > CHUNK_CAP) room = CHUNK_CAP;
        take = (left > room) ? room : left;
        c.chunk_sectors   = 7'(take);
        c.cyl_sector_word = 16'((cyl << 8) | (sector + 1) | ((cyl >> 2) & 32'hC0));
        c.head_drive_word = {8'(head), drive};
        c.buffer_segment  = addr[ADDR_W-1:4];
        c.buffer_offset   = addr[3:0];
        // The lba is not wrapped to 24 bits; the buffer address is.
        lba  = lba + take;
        addr = addr + ADDR_W'(take << SECTOR_SH);
        left = left - take;
        c.last_chunk = (left == 0);
        expected_chunks.push_back(c);
        n++;
      end while (left > 0 && n < MAX_REQUEST);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    // Compare one accepted chunk beat with the oldest prediction.
    function void check_chunk(chunk_t got);
      chunk_t exp_c;
      if (expected_chunks.size() == 0) begin
        $error("chunk beat with no request pending: 0x%0h", got);
        errors++;
        return;
      end
      exp_c = expected_chunks.pop_front();
      compare_field("chunk_sectors", exp_c.chunk_sectors, got.chunk_sectors);
      compare_field("cyl_sector_word", exp_c.cyl_sector_word, got.cyl_sector_word);
      compare_field("head_drive_word", exp_c.head_drive_word, got.head_drive_word);
      compare_field("buffer_segment", exp_c.buffer_segment, got.buffer_segment);
      compare_field("buffer_offset", exp_c.buffer_offset, got.buffer_offset);
      compare_field("last_chunk", exp_c.last_chunk, got.last_chunk);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  chunk_scoreboard sb = new();

  lchs_stream_if #(.payload_t(req_t))   req_if ();
  lchs_stream_if #(.payload_t(chunk_t)) chunk_if ();
  lchs_stream_if #(.payload_t(cfg_t))   cfg_if ();

  lba_to_chs_read_splitter #(
    .MAX_REQUEST(MAX_REQUEST),
    .CHUNK_CAP  (CHUNK_CAP)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_chunk(chunk_if),
    .cfg_wr   (cfg_if)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random at the current idling rate.
  always @(negedge clk) begin
    chunk_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Accepted beats on all three channels feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.payload.reg_index,
                                                   cfg_if.payload.wr_data);
      if (req_if.valid && req_if.ready) sb.note_request(req_if.payload);
      if (chunk_if.valid && chunk_if.ready) sb.check_chunk(chunk_if.payload);
    end
  end

  // Timeout guard.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Send one request beat; valid stays high on return so that a following
  // beat can go out without a gap.
  task automatic send_req(input logic [LBA_W-1:0] lba, input logic [COUNT_W-1:0] cnt,
                          input logic [ADDR_W-1:0] addr);
    req_t req;
    req.start_block    = lba;
    req.sector_total   = cnt;
    req.buffer_address = addr;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= req;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random request, mostly ordinary sizes, with track ends and buffer tops.
  task automatic send_random_req();
    int unsigned spt_eff;
    int unsigned lba;
    int unsigned cnt;
    int unsigned addr;
    int unsigned pick;
    spt_eff = (sb.spt == 0) ? 1 : sb.spt;
    pick = $urandom_range(99);
    if (pick < 50) lba = $urandom_range(24'hFFFFFF, 0);
    else if (pick < 75) lba = $urandom_range(4095, 0);
    else lba = ($urandom_range(200000, 0) * spt_eff + spt_eff - 1) & 24'hFFFFFF;
    pick = $urandom_range(99);
    if (pick < 10) cnt = $urandom_range(127, 65);
    else if (pick < 25) cnt = $urandom_range(3, 0);
    else cnt = $urandom_range(64, 0);
    if ($urandom_range(9) == 0) addr = 20'hFFFFF - $urandom_range(4095, 0);
    else addr = $urandom_range(20'hFFFFF, 0);
    send_req(LBA_W'(lba), COUNT_W'(cnt), ADDR_W'(addr));
  endtask

  // Stop sending and wait until every predicted chunk has arrived.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write all geometry registers plus the unused index; spare data bits are random.
  task automatic write_settings(input logic [SPT_W-1:0] s, input logic [HEADS_W-1:0] h,
                                input logic [DRIVE_W-1:0] d);
    cfg_t beat;
    int i;
    for (i = 0; i < 4; i++) begin
      case (i)
        0: begin
          beat.reg_index = REG_SPT;
          beat.wr_data   = {3'($urandom), s};
        end
        1: begin
          beat.reg_index = REG_HEADS;
          beat.wr_data   = h;
        end
        2: begin
          beat.reg_index = REG_DRIVE;
          beat.wr_data   = {1'($urandom), d};
        end
        default: begin
          beat.reg_index = REG_NONE;
          beat.wr_data   = 9'($urandom);
        end
      endcase
      cfg_if.valid   <= 1'b1;
      cfg_if.payload <= beat;
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Main sequence.
  initial begin
    int unsigned p;
    int unsigned k;
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.payload   = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.payload   = '0;
    set_idling(13, 59);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests at reset geometry: field extremes, zero and
    // oversized counts, buffer wrap, track crossing and high cylinder bits.
    send_req(24'd0, 7'd1, 20'h00000);
    send_req(24'd0, 7'd0, 20'hFFFFF);
    send_req(24'hFFFFFF, 7'd64, 20'hFFFFF);
    send_req(24'd17, 7'd20, 20'h12345);
    send_req(24'd1000, 7'd127, 20'hFFE00);
    send_req(24'h5555AA, 7'h2A, 20'hAAAAA);
    send_req(24'hAAAA55, 7'h55, 20'h55555);
    send_req(24'd9216, 7'd5, 20'h00010);
    send_req(24'd18432, 7'd3, 20'h00F00);
    send_req(24'd27683, 7'd2, 20'h0FFFF);

    // Widest geometry, with the top head and requests that cross tracks.
    wait_idle();
    write_settings(6'd63, 9'd256, 8'hFF);
    send_req(24'd16467262, 7'd64, 20'h00000);
    send_req(24'd16065, 7'd64, 20'hFFFFF);
    send_req(24'hFFFFFF, 7'd1, 20'h00000);

    // Zero geometry registers act as one.
    wait_idle();
    write_settings(6'd0, 9'd0, 8'h81);
    send_req(24'd5, 7'd3, 20'h00001);
    send_req(24'hFFFFFF, 7'd64, 20'hFFFF0);
    send_req(24'd77, 7'd0, 20'h80000);

    // Head count above 256: the head is cut to 8 bits in the head word.
    wait_idle();
    write_settings(6'd1, 9'd511, 8'h7E);
    send_req(24'd300, 7'd10, 20'h00000);
    send_req(24'hFFFFFF, 7'd64, 20'hFFFF0);
    send_req(24'd510, 7'd4, 20'h12340);

    // Random phases, each under its own geometry, with three idling patterns in turn.
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: write_settings(SPT_RESET, HEADS_RESET, DRIVE_RESET);
        1: write_settings(6'd63, 9'd256, 8'hFF);
        3: write_settings(6'd1, 9'd1, 8'h33);
        4: write_settings(6'd0, 9'd0, 8'($urandom));
        6: write_settings(6'd63, 9'd511, 8'h80);
        8: write_settings(6'd9, 9'd16, 8'hFF);
        default: write_settings(6'($urandom), 9'($urandom), 8'($urandom));
      endcase
      if (p < 3) set_idling(13, 59);
      else if (p < 6) set_idling(59, 13);
      else set_idling(0, 0);
      for (k = 0; k < PHASE_ITEMS; k++) send_random_req();
    end

    // Drain, then watch for stray beats a little longer.
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
